>>> src/tlbpt_pkg.sv
// Package for the TLB / page table translator: fixed address geometry,
// TLB command and result structs, and the sequencer state encoding.
// No dependencies.
package tlbpt_pkg;

  localparam int ADDR_W      = 16;
  localparam int OFFSET_BITS = 8;
  localparam int PAGE_W      = ADDR_W - OFFSET_BITS;
  localparam int PAGE_COUNT  = 1 << PAGE_W;
  localparam int FRAME_W     = 8;
  localparam int FRAME_COUNT = 1 << FRAME_W;
  localparam int CNT_W       = 9;
  localparam int TOTAL_W     = 32;

  localparam logic [CNT_W-1:0] FRAME_COUNT_C = CNT_W'(FRAME_COUNT);
  localparam logic [CNT_W-1:0] PAGE_COUNT_C  = CNT_W'(PAGE_COUNT);

  typedef struct packed {
    logic               insert;
    logic               inval;
    logic [PAGE_W-1:0]  page;
    logic [FRAME_W-1:0] frame;
  } tlb_cmd_t;

  typedef struct packed {
    logic               hit;
    logic [FRAME_W-1:0] frame;
  } tlb_res_t;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_PT    = 6'b000100,
    S_LRU   = 6'b001000,
    S_SWEEP = 6'b010000,
    S_DONE  = 6'b100000
  } seq_state_t;

endpackage

>>> src/tlbpt_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module tlbpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/tlbpt_tlb.sv
// FIFO-replaced, fully associative TLB held in flip-flops.
// Depends on tlbpt_pkg for the command and result structs.
module tlbpt_tlb #(
  parameter int TLB_DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [tlbpt_pkg::PAGE_W-1:0] lookup_page,
  input  tlbpt_pkg::tlb_cmd_t       cmd,
  output tlbpt_pkg::tlb_res_t       res
);
  import tlbpt_pkg::*;

  localparam int IW = (TLB_DEPTH > 1) ? $clog2(TLB_DEPTH) : 1;
  localparam logic [IW-1:0] LAST = IW'(TLB_DEPTH - 1);

  logic [TLB_DEPTH-1:0] valid_r, valid_nxt;
  logic [PAGE_W-1:0]    page_r  [TLB_DEPTH];
  logic [FRAME_W-1:0]   frame_r [TLB_DEPTH];
  logic [IW-1:0]        ptr_r, ptr_nxt;

  // Lowest matching index wins.
  always_comb begin
    res = '0;
    for (int i = TLB_DEPTH - 1; i >= 0; i--) begin
      if (valid_r[i] && page_r[i] == lookup_page) begin
        res.hit   = 1'b1;
        res.frame = frame_r[i];
      end
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    ptr_nxt   = ptr_r;
    if (cmd.inval) begin
      for (int i = 0; i < TLB_DEPTH; i++) begin
        if (frame_r[i] == cmd.frame) begin
          valid_nxt[i] = 1'b0;
        end
      end
    end
    if (cmd.insert) begin
      valid_nxt[ptr_r] = 1'b1;
      ptr_nxt = (ptr_r == LAST) ? '0 : ptr_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      ptr_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      ptr_r   <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      page_r[ptr_r]  <= cmd.page;
      frame_r[ptr_r] <= cmd.frame;
    end
  end

endmodule

>>> src/tlb_page_table_lru_translator.sv
// Top level of the TLB / page table translator with LRU frame replacement.
// Depends on tlbpt_pkg, tlbpt_ram and tlbpt_tlb.
//
// Translates one 16-bit logical address per request: the upper 8 bits are the
// page and the lower 8 bits the offset. After reset the block clears the page
// table memory, one entry per cycle, and holds in_stall high while it does so.
// A request that hits in the TLB is looked up, then has its stamp updated and
// its result loaded. A TLB miss that finds the page mapped adds a page table
// memory read. A page fault adds a sweep of the page table memory, one entry
// per cycle, to drop every mapping of the chosen frame; once frames_in_use
// frames have been handed out, a least-recently-used scan of the stamp memory
// comes first. One request is in flight at a time; a finished result waits in
// the output register while the next request is taken. The configuration
// register is always ready and must be written only while the block is idle.
module tlb_page_table_lru_translator #(
  parameter int TLB_DEPTH  = 16,
  parameter int STAMP_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_frames_in_use,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_logical_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_physical_address,
  output logic        out_tlb_hit,
  output logic        out_page_fault,
  output logic        out_frame_evicted,
  output logic [31:0] out_hit_total,
  output logic [31:0] out_fault_total
);
  import tlbpt_pkg::*;

  localparam logic [STAMP_BITS-1:0] STAMP_MAX  = '1;
  localparam logic [TOTAL_W-1:0]    TOTAL_MAX  = '1;
  localparam int                    PM_W       = FRAME_W + 1;
  localparam logic [CNT_W-1:0]      CLEAR_LAST = PAGE_COUNT_C - 1'b1;

  seq_state_t state_r, state_nxt;

  logic [CNT_W-1:0]       fiu_r;
  logic [CNT_W-1:0]       usable;
  logic [PAGE_W-1:0]      page_r;
  logic [OFFSET_BITS-1:0] offset_r;
  logic [FRAME_W-1:0]     frame_r;
  logic                   hit_r, fault_r, evict_r;
  logic [CNT_W-1:0]       next_free_r, loaded_r;
  logic [STAMP_BITS-1:0]  clock_r, clock_nxt;
  logic [TOTAL_W-1:0]     hit_cnt_r, fault_cnt_r, hit_cnt_nxt, fault_cnt_nxt;

  // Scan sequencing shared by the clearing pass, the LRU scan and the sweep.
  logic [CNT_W-1:0]       cnt_r;
  logic                   pend_r;
  logic [FRAME_W-1:0]     pend_idx_r;
  logic                   first_r;
  logic [FRAME_W-1:0]     best_r;
  logic [STAMP_BITS-1:0]  best_stamp_r;

  // Valid bits for the stamp memory.
  logic [FRAME_COUNT-1:0] sv_r;

  logic                   out_valid_r;
  logic [ADDR_W-1:0]      out_pa_r;
  logic                   out_hit_r, out_fault_r, out_evict_r;

  logic                   in_acc, out_free, scan_done, sweep_done, sweep_drop;
  logic                   pm_we, st_we, pm_mapped;
  logic [PAGE_W-1:0]      pm_raddr, pm_waddr;
  logic [PM_W-1:0]        pm_rdata, pm_wdata;
  logic [STAMP_BITS-1:0]  st_rdata, st_eff;
  logic [CNT_W-1:0]       scan_lim;

  tlb_cmd_t tlb_cmd;
  tlb_res_t tlb_res;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    if (fiu_r == '0) begin
      usable = CNT_W'(1);
    end else if (fiu_r > FRAME_COUNT_C) begin
      usable = FRAME_COUNT_C;
    end else begin
      usable = fiu_r;
    end
  end

  tlbpt_tlb #(.TLB_DEPTH(TLB_DEPTH)) u_tlb (
    .clk         (clk),
    .rst_n       (rst_n),
    .lookup_page (in_logical_address[ADDR_W-1:OFFSET_BITS]),
    .cmd         (tlb_cmd),
    .res         (tlb_res)
  );

  assign pm_raddr = (state_r == S_SWEEP) ? cnt_r[PAGE_W-1:0]
                                         : in_logical_address[ADDR_W-1:OFFSET_BITS];

  // Each page table entry holds a valid bit above the frame number. The
  // memory is written by the clearing pass, by the sweep when it drops a
  // mapping of the chosen frame, and at the end of the sweep with the new
  // mapping.
  assign pm_mapped  = pm_rdata[FRAME_W];
  assign sweep_drop = (state_r == S_SWEEP) && pend_r && pm_mapped &&
                      (pm_rdata[FRAME_W-1:0] == frame_r);
  assign pm_we      = (state_r == S_CLEAR) || sweep_drop || sweep_done;
  assign pm_waddr   = (state_r == S_CLEAR) ? cnt_r[PAGE_W-1:0] :
                      sweep_done           ? page_r : pend_idx_r;
  assign pm_wdata   = sweep_done ? {1'b1, frame_r} : '0;

  tlbpt_ram #(.WIDTH(PM_W), .DEPTH(PAGE_COUNT)) u_page_ram (
    .clk   (clk),
    .we    (pm_we),
    .waddr (pm_waddr),
    .wdata (pm_wdata),
    .raddr (pm_raddr),
    .rdata (pm_rdata)
  );

  tlbpt_ram #(.WIDTH(STAMP_BITS), .DEPTH(FRAME_COUNT)) u_stamp_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (frame_r),
    .wdata (clock_nxt),
    .raddr (cnt_r[FRAME_W-1:0]),
    .rdata (st_rdata)
  );

  // A frame that was never stamped reads as zero.
  assign st_eff     = sv_r[pend_idx_r] ? st_rdata : '0;
  assign scan_lim   = (state_r == S_LRU) ? usable : PAGE_COUNT_C;
  assign scan_done  = (cnt_r == scan_lim) && !pend_r;
  assign sweep_done = (state_r == S_SWEEP) && scan_done;
  assign st_we      = (state_r == S_DONE) && out_free;

  assign clock_nxt     = (clock_r == STAMP_MAX) ? clock_r : clock_r + 1'b1;
  assign hit_cnt_nxt   = (hit_r && hit_cnt_r != TOTAL_MAX) ? hit_cnt_r + 1'b1 : hit_cnt_r;
  assign fault_cnt_nxt = (fault_r && fault_cnt_r != TOTAL_MAX) ? fault_cnt_r + 1'b1
                                                                : fault_cnt_r;

  always_comb begin
    tlb_cmd        = '0;
    tlb_cmd.page   = page_r;
    tlb_cmd.frame  = frame_r;
    tlb_cmd.inval  = sweep_done;
    tlb_cmd.insert = st_we && !hit_r;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (cnt_r == CLEAR_LAST) state_nxt = S_IDLE;
      S_IDLE:  if (in_acc) state_nxt = tlb_res.hit ? S_DONE : S_PT;
      S_PT: begin
        if (pm_mapped) begin
          state_nxt = S_DONE;
        end else if (loaded_r >= usable) begin
          state_nxt = S_LRU;
        end else begin
          state_nxt = S_SWEEP;
        end
      end
      S_LRU:   if (scan_done) state_nxt = S_SWEEP;
      S_SWEEP: if (scan_done) state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      fiu_r       <= FRAME_COUNT_C;
      next_free_r <= '0;
      loaded_r    <= '0;
      clock_r     <= '0;
      hit_cnt_r   <= '0;
      fault_cnt_r <= '0;
      sv_r        <= '0;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      cnt_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        fiu_r <= cfg_frames_in_use;
      end
      if (state_r == S_PT && !pm_mapped && loaded_r < usable) begin
        next_free_r <= next_free_r + 1'b1;
      end
      if (state_r == S_CLEAR) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (state_r == S_PT) begin
        cnt_r  <= '0;
        pend_r <= 1'b0;
      end else if (state_r == S_LRU || state_r == S_SWEEP) begin
        if (scan_done) begin
          cnt_r  <= '0;
        end else if (cnt_r != scan_lim) begin
          cnt_r <= cnt_r + 1'b1;
        end
        pend_r <= (cnt_r != scan_lim);
      end
      if (sweep_done) begin
        if (loaded_r < FRAME_COUNT_C) begin
          loaded_r <= loaded_r + 1'b1;
        end
      end
      if (st_we) begin
        clock_r       <= clock_nxt;
        sv_r[frame_r] <= 1'b1;
        hit_cnt_r     <= hit_cnt_nxt;
        fault_cnt_r   <= fault_cnt_nxt;
        out_valid_r   <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Request payload and scan datapath.
  always_ff @(posedge clk) begin
    pend_idx_r <= cnt_r[FRAME_W-1:0];
    if (in_acc) begin
      page_r   <= in_logical_address[ADDR_W-1:OFFSET_BITS];
      offset_r <= in_logical_address[OFFSET_BITS-1:0];
      hit_r    <= tlb_res.hit;
      frame_r  <= tlb_res.frame;
      fault_r  <= 1'b0;
      evict_r  <= 1'b0;
    end
    if (state_r == S_PT) begin
      first_r <= 1'b1;
      if (pm_mapped) begin
        frame_r <= pm_rdata[FRAME_W-1:0];
      end else begin
        fault_r <= 1'b1;
        frame_r <= next_free_r[FRAME_W-1:0];
      end
    end
    if (state_r == S_LRU) begin
      if (pend_r && (first_r || st_eff < best_stamp_r)) begin
        best_r       <= pend_idx_r;
        best_stamp_r <= st_eff;
        first_r      <= 1'b0;
      end
      if (scan_done) begin
        frame_r <= best_r;
      end
    end
    if (sweep_drop) begin
      evict_r <= 1'b1;
    end
    if (st_we) begin
      out_pa_r    <= {frame_r, offset_r};
      out_hit_r   <= hit_r;
      out_fault_r <= fault_r;
      out_evict_r <= evict_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_physical_address = out_pa_r;
  assign out_tlb_hit          = out_hit_r;
  assign out_page_fault       = out_fault_r;
  assign out_frame_evicted    = out_evict_r;
  assign out_hit_total        = hit_cnt_r;
  assign out_fault_total      = fault_cnt_r;

  // A result is either a TLB hit or possibly a fault, never both.
  a_hit_not_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_hit_r && out_fault_r))
    else $error("tlb hit and page fault reported together");

  // Eviction is only reported on a fault.
  a_evict_on_fault: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_evict_r |-> out_fault_r)
    else $error("eviction without page fault");

  // The loaded-frame count never passes the frame count.
  a_loaded_bound: assert property (@(posedge clk) disable iff (!rst_n)
    loaded_r <= FRAME_COUNT_C)
    else $error("frames loaded exceeds frame count");

  // A request entering the page table path never stays idle afterwards.
  a_miss_path: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !tlb_res.hit |=> state_r == S_PT)
    else $error("tlb miss did not start page table read");

endmodule

>>> dv/tlb_page_table_lru_translator_tb.sv
// Self-checking testbench for the TLB / page table translator with LRU frame
// replacement. Depends on tlbpt_pkg and the tlb_page_table_lru_translator RTL.
// A scoreboard class mirrors the translation state and checks every result.
module tlb_page_table_lru_translator_tb;
  import tlbpt_pkg::*;

  localparam int TLB_SLOTS = 16;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [15:0] physical_address;
    logic        tlb_hit;
    logic        page_fault;
    logic        frame_evicted;
    logic [31:0] hit_total;
    logic [31:0] fault_total;
  } xlat_t;

  // Mirror of the translator: page table, frame stamps, FIFO TLB, counters.
  class xlat_scoreboard;
    bit          map_ok[PAGE_COUNT];
    bit [8:0]    map_frame[PAGE_COUNT];
    bit [31:0]   stamp[FRAME_COUNT];
    bit          tlb_ok[TLB_SLOTS];
    bit [7:0]    tlb_pg[TLB_SLOTS];
    bit [8:0]    tlb_fr[TLB_SLOTS];
    bit [3:0]    fill_ptr;
    bit [8:0]    free_frame;
    bit [8:0]    loaded;
    bit [31:0]   clock_now;
    bit [31:0]   hits;
    bit [31:0]   faults;
    bit [8:0]    frames_cfg;
    xlat_t       pending[$];
    int          errors;
    int          n_hits, n_faults, n_evicts, n_checked;

    function void reset_state();
      foreach (map_ok[i]) begin
        map_ok[i] = 0; map_frame[i] = 0;
      end
      foreach (stamp[i]) stamp[i] = 0;
      foreach (tlb_ok[i]) begin
        tlb_ok[i] = 0; tlb_pg[i] = 0; tlb_fr[i] = 0;
      end
      fill_ptr = 0; free_frame = 0; loaded = 0; clock_now = 0;
      hits = 0; faults = 0; frames_cfg = 9'd256;
    endfunction

    // Predicts the translation of one accepted request and queues it.
    function void note_request(bit [15:0] addr);
      bit [7:0] pg;
      bit [8:0] fr;
      bit hit, flt, ev;
      int n, lim;
      bit [31:0] best;
      pg = addr[15:8];
      fr = 0; hit = 0; flt = 0; ev = 0;
      for (int i = 0; i < TLB_SLOTS; i++)
        if (!hit && tlb_ok[i] && tlb_pg[i] == pg) begin
          hit = 1; fr = tlb_fr[i];
        end
      if (hit) begin
        if (hits != '1) hits++;
      end else begin
        if (map_ok[pg]) fr = map_frame[pg];
        else begin
          flt = 1;
          lim = (frames_cfg == 0) ? 1 : (frames_cfg > FRAME_COUNT ? FRAME_COUNT : frames_cfg);
          if (loaded >= lim) begin
            // Least recently used frame, lowest index wins ties.
            n = 0; best = stamp[0];
            for (int i = 1; i < lim; i++)
              if (stamp[i] < best) begin
                best = stamp[i]; n = i;
              end
            fr = 9'(n);
          end else begin
            fr = 9'(free_frame % FRAME_COUNT);
            free_frame++;
          end
          for (int i = 0; i < PAGE_COUNT; i++)
            if (map_ok[i] && map_frame[i] == fr) begin
              map_ok[i] = 0; ev = 1;
            end
          for (int i = 0; i < TLB_SLOTS; i++)
            if (tlb_ok[i] && tlb_fr[i] == fr) tlb_ok[i] = 0;
          map_ok[pg] = 1; map_frame[pg] = fr;
          if (loaded < FRAME_COUNT) loaded++;
          if (faults != '1) faults++;
        end
        tlb_ok[fill_ptr] = 1; tlb_pg[fill_ptr] = pg; tlb_fr[fill_ptr] = fr;
        fill_ptr++;
      end
      fr = 9'(fr % FRAME_COUNT);
      if (clock_now != '1) clock_now++;
      stamp[fr] = clock_now;
      pending.push_back('{{fr[7:0], addr[7:0]}, hit, flt, ev, hits, faults});
      n_hits += hit; n_faults += flt; n_evicts += ev;
    endfunction

    function void check_result(xlat_t got);
      xlat_t exp;
      if (pending.size() == 0) begin
        $error("unexpected result, physical_address %h", got.physical_address);
        errors++;
        return;
      end
      exp = pending.pop_front();
      n_checked++;
      if (got.physical_address !== exp.physical_address) begin
        $error("physical_address exp %h got %h", exp.physical_address, got.physical_address);
        errors++;
      end
      if (got.tlb_hit !== exp.tlb_hit) begin
        $error("tlb_hit exp %b got %b", exp.tlb_hit, got.tlb_hit); errors++;
      end
      if (got.page_fault !== exp.page_fault) begin
        $error("page_fault exp %b got %b", exp.page_fault, got.page_fault); errors++;
      end
      if (got.frame_evicted !== exp.frame_evicted) begin
        $error("frame_evicted exp %b got %b", exp.frame_evicted, got.frame_evicted);
        errors++;
      end
      if (got.hit_total !== exp.hit_total) begin
        $error("hit_total exp %0d got %0d", exp.hit_total, got.hit_total); errors++;
      end
      if (got.fault_total !== exp.fault_total) begin
        $error("fault_total exp %0d got %0d", exp.fault_total, got.fault_total); errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [8:0]  cfg_frames_in_use = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [15:0] in_logical_address = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [15:0] out_physical_address;
  logic        out_tlb_hit, out_page_fault, out_frame_evicted;
  logic [31:0] out_hit_total, out_fault_total;

  // Idling is switched off during a calm stretch in the middle of the run.
  bit calm = 0;
  int idle_pct = 38;
  int idle_cnt = 0;
  xlat_scoreboard sb;

  always #5 clk = ~clk;

  tlb_page_table_lru_translator uut (.*);

  // Receiver: random stalls, and a check on every accepted result.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result('{out_physical_address, out_tlb_hit, out_page_fault,
                        out_frame_evicted, out_hit_total, out_fault_total});
    out_stall <= !calm && ($urandom_range(99) < idle_pct);
  end

  // Watchdog: counts cycles in which neither channel moves a request.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= WATCHDOG_LIMIT) begin
      $display("tlb_page_table_lru_translator_tb: errors");
      $finish;
    end
  end

  // Sends one request, with an optional random gap before it. Valid stays
  // high after acceptance; a drain lowers it, as does the next send during a gap.
  task automatic send(bit [15:0] addr);
    while (!calm && $urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    in_logical_address <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(addr);
  endtask

  // Waits until every expected result is back, then lets any sweep finish.
  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
  endtask

  // Writes the frame count; only called while the block is idle.
  task automatic set_frames(bit [8:0] n);
    cfg_valid <= 1;
    cfg_frames_in_use <= n;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 0;
    // An over-range value acts as the full frame count in the mirror too.
    sb.frames_cfg = n;
  endtask

  // Random addresses biased toward a small working set so hits are common.
  function automatic bit [15:0] pick_addr(int pages);
    bit [7:0] pg;
    if ($urandom_range(9) == 0) pg = 8'($urandom);
    else pg = 8'($urandom_range(pages - 1));
    return {pg, 8'($urandom)};
  endfunction

  initial begin
    bit [8:0] settings[5] = '{9'd1, 9'd0, 9'd4, 9'd511, 9'd256};
    sb = new();
    sb.reset_state();
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: address extremes, repeat hits, then a fill past the TLB.
    send(16'h0000); send(16'hFFFF); send(16'h00FF); send(16'hFF00);
    send(16'h0000); send(16'hFFAA); send(16'h5555); send(16'hAAAA);
    for (int i = 1; i <= 17; i++) send({8'(i), 8'(i * 7)});
    drain();

    // Random phases under several frame counts, the extremes among them.
    foreach (settings[s]) begin
      set_frames(settings[s]);
      for (int i = 0; i < 200; i++) begin
        calm = (s == 2 && i >= 50 && i < 150);
        if (s == 1 && i == 100) drain();
        send(pick_addr(settings[s] == 9'd4 ? 8 : 24));
      end
      calm = 0;
      drain();
    end

    $display("Checked %0d translations: %0d TLB hits, %0d faults, %0d evictions.",
             sb.n_checked, sb.n_hits, sb.n_faults, sb.n_evicts);
    if (sb.errors == 0) $display("tlb_page_table_lru_translator_tb: clean");
    else $display("tlb_page_table_lru_translator_tb: errors");
    $finish;
  end

endmodule
